// ===== rtl/ghar_pkg.sv =====
// Shared types and constants for the gesture hold auto-repeat block.
// No dependencies; the RTL files take names from here by scope, the testbench imports them.
package ghar_pkg;

    localparam int TIME_BITS = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int COUNT_W = 8;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [COUNT_W-1:0] count_t;

    // Sample kind codes
    localparam logic FUNC_GESTURE = 1'b0;
    localparam logic FUNC_BUTTON = 1'b1;

    // Gesture code meaning no motion
    localparam logic [1:0] GESTURE_NONE = 2'd0;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIME = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARM_TIME = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TIME = 3'd4;

    // Register values after reset
    localparam logic [15:0] GAP_TIME_RST = 16'd300;
    localparam logic [15:0] ARM_TIME_RST = 16'd500;
    localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd1000;
    localparam logic [7:0] COUNT_LIMIT_RST = 8'd10;
    localparam logic [15:0] DEBOUNCE_TIME_RST = 16'd30;

    typedef struct packed {
        logic        func;
        logic [31:0] now_ms;
        logic [1:0]  gesture_code;
        logic        button_level;
    } sample_t;

    typedef struct packed {
        logic        add_event;
        logic        flush_event;
        logic [7:0]  count_now;
        logic [7:0]  flushed_count;
    } result_t;

endpackage

// ===== rtl/ghar_sample_if.sv =====
// Valid/ready channel that carries one input sample per transfer.
// Depends on ghar_pkg for the payload type.
interface ghar_sample_if;
    logic               valid;
    logic               ready;
    ghar_pkg::sample_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ghar_result_if.sv =====
// Valid/ready channel that carries one result item per transfer.
// Depends on ghar_pkg for the payload type.
interface ghar_result_if;
    logic               valid;
    logic               ready;
    ghar_pkg::result_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ghar_debounce.sv =====
// Button debouncer: tracks raw level changes and reports a debounced press edge.
// Depends on ghar_pkg for the time type.
module ghar_debounce (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_en,
    input  logic              level,
    input  ghar_pkg::time_t   now,
    input  logic [15:0]       debounce_time,
    output logic              press
);

    logic            prev_raw_reg;
    logic            prev_raw_next;
    logic            stable_reg;
    logic            stable_next;
    ghar_pkg::time_t change_time_reg;
    ghar_pkg::time_t change_time_next;
    ghar_pkg::time_t since_change;
    logic            settled;

    assign since_change = now - change_time_reg;
    assign settled = since_change >= ghar_pkg::TIME_BITS'(debounce_time);

    always_comb
    begin
        prev_raw_next = prev_raw_reg;
        stable_next = stable_reg;
        change_time_next = change_time_reg;
        press = 1'b0;
        if (sample_en)
        begin
            if (level != prev_raw_reg)
            begin
                // restart the stability window
                prev_raw_next = level;
                change_time_next = now;
            end
            else if (level != stable_reg && settled)
            begin
                stable_next = level;
                press = level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_raw_reg <= 1'b0;
            stable_reg <= 1'b0;
            change_time_reg <= '0;
        end
        else
        begin
            prev_raw_reg <= prev_raw_next;
            stable_reg <= stable_next;
            change_time_reg <= change_time_next;
        end
    end

endmodule

// ===== rtl/gesture_hold_auto_repeat.sv =====
// Top level of the gesture hold auto-repeat counter with a debounced flush button.
// Depends on ghar_pkg, ghar_sample_if, ghar_result_if and ghar_debounce.

// One sample is taken per transfer on the sample channel and answered by exactly
// one result on the result channel. The whole update (hold, arming, repeat timing,
// saturating count, debounce and flush) is evaluated in the cycle of the transfer
// and lands in the result register on the same edge. A new sample can be taken
// every cycle: the sample side stalls only while a result is held and the result
// side is not taking it. Times are compared as wrapping differences over a 32-bit
// millisecond stamp. A gesture must persist for arm_time before its first add,
// which comes at once; further adds follow every repeat_interval. Idle samples
// keep the hold until the idle stretch reaches gap_time. A debounced button press
// clears the count and reports the old value. The user must write configuration
// registers through cfg_we/cfg_index/cfg_data only while the block is idle; the
// block itself does not enforce this, and writes to unused indexes are dropped.
module gesture_hold_auto_repeat (
    input  logic                                  clk,
    input  logic                                  rst_n,
    ghar_sample_if.sink                           sample,
    ghar_result_if.source                         result,
    input  logic                                  cfg_we,
    input  logic [ghar_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [ghar_pkg::CFG_DATA_W-1:0]       cfg_data
);

    // Configuration registers
    logic [15:0]       gap_time_reg;
    logic [15:0]       arm_time_reg;
    logic [15:0]       repeat_interval_reg;
    logic [7:0]        count_limit_reg;
    logic [15:0]       debounce_time_reg;

    // Gesture tracking state
    ghar_pkg::time_t   idle_start_reg;
    ghar_pkg::time_t   idle_start_next;
    logic              armed_reg;
    logic              armed_next;
    logic [1:0]        held_gesture_reg;
    logic [1:0]        held_gesture_next;
    ghar_pkg::time_t   hold_start_reg;
    ghar_pkg::time_t   hold_start_next;
    ghar_pkg::time_t   last_add_reg;
    ghar_pkg::time_t   last_add_next;
    ghar_pkg::count_t  count_reg;
    ghar_pkg::count_t  count_next;

    // Result register
    logic              out_valid_reg;
    ghar_pkg::result_t out_data_reg;
    ghar_pkg::result_t out_data_next;

    logic              take;
    logic              is_gesture;
    logic              is_button;
    ghar_pkg::time_t   now;
    logic              gesture_change;
    ghar_pkg::time_t   hold_base;
    logic              armed_base;
    ghar_pkg::time_t   idle_base;
    logic              arm_now;
    logic              repeat_due;
    logic              add_fire;
    logic              press;

    // Hold a finished result while the sink stalls, but let a new sample in
    // on the same edge that the held result transfers.
    assign sample.ready = !out_valid_reg || result.ready;
    assign take = sample.valid && sample.ready;
    assign is_gesture = take && (sample.data.func == ghar_pkg::FUNC_GESTURE);
    assign is_button = take && (sample.data.func == ghar_pkg::FUNC_BUTTON);
    assign now = ghar_pkg::time_t'(sample.data.now_ms);

    ghar_debounce u_debounce (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_en     (is_button),
        .level         (sample.data.button_level),
        .now           (now),
        .debounce_time (debounce_time_reg),
        .press         (press)
    );

    // A different gesture restarts the hold from this sample and drops arming.
    assign gesture_change = sample.data.gesture_code != held_gesture_reg;
    assign hold_base = gesture_change ? now : hold_start_reg;
    assign armed_base = gesture_change ? 1'b0 : armed_reg;

    // Zero marks "not idle", so an idle stretch that opens at time zero starts at one.
    always_comb
    begin
        if (idle_start_reg != '0)
            idle_base = idle_start_reg;
        else if (now != '0)
            idle_base = now;
        else
            idle_base = ghar_pkg::time_t'(1);
    end

    // The arming sample fires an add itself, so the first add is immediate.
    assign arm_now = !armed_base
        && ((now - hold_base) >= ghar_pkg::TIME_BITS'(arm_time_reg));
    assign repeat_due = (now - last_add_reg) >= ghar_pkg::TIME_BITS'(repeat_interval_reg);
    assign add_fire = arm_now || (armed_base && repeat_due);

    always_comb
    begin
        idle_start_next = idle_start_reg;
        armed_next = armed_reg;
        held_gesture_next = held_gesture_reg;
        hold_start_next = hold_start_reg;
        last_add_next = last_add_reg;
        count_next = count_reg;
        out_data_next = '0;

        if (is_gesture)
        begin
            if (sample.data.gesture_code == ghar_pkg::GESTURE_NONE)
            begin
                idle_start_next = idle_base;
                if ((now - idle_base) >= ghar_pkg::TIME_BITS'(gap_time_reg))
                begin
                    // idle too long: drop the hold
                    armed_next = 1'b0;
                    held_gesture_next = ghar_pkg::GESTURE_NONE;
                end
            end
            else
            begin
                idle_start_next = '0;
                held_gesture_next = sample.data.gesture_code;
                hold_start_next = hold_base;
                armed_next = armed_base || arm_now;
                if (add_fire)
                begin
                    last_add_next = now;
                    if (count_reg < count_limit_reg)
                        count_next = count_reg + 8'd1;
                end
                out_data_next.add_event = add_fire;
            end
        end
        else if (is_button && press)
        begin
            // flush: report the old count, restart from zero
            count_next = '0;
            out_data_next.flush_event = 1'b1;
            out_data_next.flushed_count = count_reg;
        end
        out_data_next.count_now = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_time_reg <= ghar_pkg::GAP_TIME_RST;
            arm_time_reg <= ghar_pkg::ARM_TIME_RST;
            repeat_interval_reg <= ghar_pkg::REPEAT_INTERVAL_RST;
            count_limit_reg <= ghar_pkg::COUNT_LIMIT_RST;
            debounce_time_reg <= ghar_pkg::DEBOUNCE_TIME_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ghar_pkg::CFG_GAP_TIME:        gap_time_reg <= cfg_data;
                ghar_pkg::CFG_ARM_TIME:        arm_time_reg <= cfg_data;
                ghar_pkg::CFG_REPEAT_INTERVAL: repeat_interval_reg <= cfg_data;
                ghar_pkg::CFG_COUNT_LIMIT:     count_limit_reg <= cfg_data[7:0];
                ghar_pkg::CFG_DEBOUNCE_TIME:   debounce_time_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_start_reg <= '0;
            armed_reg <= 1'b0;
            held_gesture_reg <= ghar_pkg::GESTURE_NONE;
            hold_start_reg <= '0;
            last_add_reg <= '0;
            count_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idle_start_reg <= idle_start_next;
            armed_reg <= armed_next;
            held_gesture_reg <= held_gesture_next;
            hold_start_reg <= hold_start_next;
            last_add_reg <= last_add_next;
            count_reg <= count_next;
            if (take)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

    // A flush always leaves the count at zero.
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.flush_event) |-> (out_data_reg.count_now == 8'd0))
        else $error("flush result with nonzero count");

    // A sample never both adds and flushes; no flush means no reported count.
    a_flush_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!(out_data_reg.add_event && out_data_reg.flush_event)
            && (out_data_reg.flush_event || out_data_reg.flushed_count == 8'd0)))
        else $error("inconsistent add/flush result");

    // A button sample never produces an add.
    a_button_no_add: assert property (@(posedge clk) disable iff (!rst_n)
        is_button |=> (out_valid_reg && !out_data_reg.add_event))
        else $error("button sample produced an add");

    // The count register moves only on a transfer.
    a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !take |=> $stable(count_reg))
        else $error("count changed without a sample");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for gesture_hold_auto_repeat: a directed table and then random
// phases, results checked against typed rows or a cycle-free hold/repeat/flush predictor.
// Depends on ghar_pkg, ghar_sample_if, ghar_result_if and the block's RTL.
module tb;
    import ghar_pkg::*;

    // Motion codes above idle, used by the directed table
    localparam logic [1:0] GESTURE_SWAY     = 2'd1;
    localparam logic [1:0] GESTURE_PUMP     = 2'd2;
    localparam logic [1:0] GESTURE_VIGOROUS = 2'd3;

    // Abort when this many cycles pass with no transfer on either channel
    localparam int STALL_LIMIT   = 2000;
    // Length of the deliberate receiver hold-off
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 125;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

    // One line of the directed table: either a register write or a sample,
    // optionally with the result typed in by hand
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] cfg_idx;
        logic [15:0]          cfg_val;
        sample_t              smp;
        bit                   typed;
        result_t              want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ghar_sample_if sample_ch ();
    ghar_result_if result_ch ();

    gesture_hold_auto_repeat dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor: its own copy of the registers and of the block state.
    // ------------------------------------------------------------------
    logic [15:0] cfg_gap      = GAP_TIME_RST;
    logic [15:0] cfg_arm      = ARM_TIME_RST;
    logic [15:0] cfg_repeat   = REPEAT_INTERVAL_RST;
    count_t      cfg_limit    = COUNT_LIMIT_RST;
    logic [15:0] cfg_debounce = DEBOUNCE_TIME_RST;

    time_t      idle_mark     = '0;   // zero means no idle stretch is running
    logic       armed         = 1'b0;
    logic [1:0] held_code     = GESTURE_NONE;
    time_t      held_since    = '0;
    time_t      prev_add_stamp = '0;
    count_t     tally         = '0;
    logic       btn_raw_prev  = 1'b0;
    logic       btn_debounced = 1'b0;
    time_t      btn_edge_ms   = '0;

    result_t pending_results [$];
    int      mismatches = 0;
    int      burst_left = 0;
    bit      hold_off_req = 1'b0;

    // Advance the predicted state by one sample and return its result.
    // All time differences wrap at 32 bits through time_t arithmetic.
    function automatic result_t predict_tally(sample_t s);
        result_t r;
        time_t   t;
        time_t   span;
        t = s.now_ms;
        r = '0;
        if (s.func == FUNC_GESTURE) begin
            if (s.gesture_code == GESTURE_NONE) begin
                // An idle stretch starting at time zero is stamped 1
                if (idle_mark == '0)
                    idle_mark = (t != '0) ? t : 32'd1;
                span = t - idle_mark;
                if (span >= cfg_gap) begin
                    armed = 1'b0;
                    held_code = GESTURE_NONE;
                end
            end
            else begin
                idle_mark = '0;
                if (s.gesture_code != held_code) begin
                    held_code = s.gesture_code;
                    held_since = t;
                    armed = 1'b0;
                end
                span = t - held_since;
                if (!armed && span >= cfg_arm) begin
                    armed = 1'b1;
                    // Back-date the last add so that the first one fires at once
                    prev_add_stamp = t - cfg_repeat;
                end
                span = t - prev_add_stamp;
                if (armed && span >= cfg_repeat) begin
                    prev_add_stamp = t;
                    if (tally < cfg_limit)
                        tally = tally + 8'd1;
                    r.add_event = 1'b1;
                end
            end
        end
        else begin
            span = t - btn_edge_ms;
            if (s.button_level != btn_raw_prev) begin
                btn_raw_prev = s.button_level;
                btn_edge_ms = t;
            end
            else if (s.button_level != btn_debounced && span >= cfg_debounce) begin
                btn_debounced = s.button_level;
                if (s.button_level) begin
                    r.flush_event = 1'b1;
                    r.flushed_count = tally;
                    tally = '0;
                end
            end
        end
        r.count_now = tally;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Every task is entered at a rising edge and returns at one.
    // ------------------------------------------------------------------

    // Offer one sample in bursts with random gaps; on the transfer, predict and
    // queue its result (or the hand-typed one for table rows that carry it).
    task automatic send_sample(input sample_t s, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                sample_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.data <= s;
        do @(posedge clk); while (!sample_ch.ready);
        burst_left--;
        predicted = predict_tally(s);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Drop valid and hold until every queued result has been taken.
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_results.size() != 0);
    endtask

    // Write one register; the caller drops cfg_we after the last write of a batch.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            CFG_GAP_TIME:        cfg_gap = val;
            CFG_ARM_TIME:        cfg_arm = val;
            CFG_REPEAT_INTERVAL: cfg_repeat = val;
            CFG_COUNT_LIMIT:     cfg_limit = val[7:0];
            CFG_DEBOUNCE_TIME:   cfg_debounce = val;
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    dir_row_t dir_rows [$];

    function automatic void add_row(input logic f, input time_t t, input logic [1:0] code,
                                    input logic lvl, input bit typed, input logic add,
                                    input logic flush, input count_t cnt, input count_t old);
        dir_row_t row;
        row.is_cfg = 1'b0;
        row.cfg_idx = '0;
        row.cfg_val = '0;
        row.smp.func = f;
        row.smp.now_ms = t;
        row.smp.gesture_code = code;
        row.smp.button_level = lvl;
        row.typed = typed;
        row.want.add_event = add;
        row.want.flush_event = flush;
        row.want.count_now = cnt;
        row.want.flushed_count = old;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg_row(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_idx = idx;
        row.cfg_val = val;
        dir_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // Main stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        sample_t     s;
        time_t       ms_now;
        logic [1:0]  cur_code;
        logic        btn_lvl;
        logic [15:0] v_gap, v_arm, v_rep, v_deb;
        count_t      v_lim;
        int unsigned step;
        int unsigned scale;
        bit          cfg_open;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        sample_ch.valid = 1'b0;
        sample_ch.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: gap 300, arm 500, repeat 1000, limit 10, debounce 30.
        // Hold sway until armed: first add at once, the next one an interval later.
        add_row(FUNC_GESTURE, 32'd0, GESTURE_SWAY, 1'b0, 1, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd500, GESTURE_SWAY, 1'b0, 1, 1, 0, 8'd1, 8'd0);
        add_row(FUNC_GESTURE, 32'd1500, GESTURE_SWAY, 1'b0, 1, 1, 0, 8'd2, 8'd0);
        // Short idle gap is bridged, then a different gesture restarts the hold
        add_row(FUNC_GESTURE, 32'd1600, GESTURE_NONE, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd1800, GESTURE_SWAY, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd1900, GESTURE_PUMP, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd2400, GESTURE_PUMP, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        // Idle exactly gap_time drops the hold
        add_row(FUNC_GESTURE, 32'd2500, GESTURE_NONE, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd2800, GESTURE_NONE, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd2810, GESTURE_PUMP, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        // Press just short of and then exactly at the debounce time: flush
        add_row(FUNC_BUTTON, 32'd3000, GESTURE_NONE, 1'b1, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_BUTTON, 32'd3029, GESTURE_NONE, 1'b1, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_BUTTON, 32'd3030, GESTURE_NONE, 1'b1, 1, 0, 1, 8'd0, 8'd3);
        // Debounced release flushes nothing
        add_row(FUNC_BUTTON, 32'd3200, GESTURE_NONE, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_BUTTON, 32'd3300, GESTURE_NONE, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        // Arm across the 32-bit wrap, with the unused button field set
        add_row(FUNC_GESTURE, 32'hFFFF_FF00, GESTURE_VIGOROUS, 1'b1, 1, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'h0000_0100, GESTURE_VIGOROUS, 1'b1, 1, 1, 0, 8'd1, 8'd0);
        // Idle at time zero
        add_row(FUNC_GESTURE, 32'd0, GESTURE_NONE, 1'b1, 0, 0, 0, 8'd0, 8'd0);
        // Press debounced across the wrap, with the unused gesture field set
        add_row(FUNC_BUTTON, 32'hFFFF_FFFF, GESTURE_VIGOROUS, 1'b1, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_BUTTON, 32'd29, GESTURE_VIGOROUS, 1'b1, 1, 0, 1, 8'd0, 8'd1);
        // Zero arm and zero repeat: every sample adds; count pins at the ceiling
        add_cfg_row(CFG_ARM_TIME, 16'd0);
        add_cfg_row(CFG_REPEAT_INTERVAL, 16'd0);
        add_cfg_row(CFG_COUNT_LIMIT, 16'd2);
        add_row(FUNC_GESTURE, 32'd100, GESTURE_SWAY, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd100, GESTURE_SWAY, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        add_row(FUNC_GESTURE, 32'd100, GESTURE_SWAY, 1'b0, 0, 0, 0, 8'd0, 8'd0);
        // Lower the limit below the count: count holds
        add_cfg_row(CFG_COUNT_LIMIT, 16'd0);
        add_row(FUNC_GESTURE, 32'd100, GESTURE_SWAY, 1'b0, 0, 0, 0, 8'd0, 8'd0);

        // Walk the table; drain before the first write of each batch of writes
        cfg_open = 1'b0;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                if (!cfg_open)
                    wait_drained();
                write_reg(dir_rows[i].cfg_idx, dir_rows[i].cfg_val);
                cfg_open = 1'b1;
            end
            else begin
                if (cfg_open) begin
                    cfg_we <= 1'b0;
                    cfg_open = 1'b0;
                end
                send_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        // Random phases: one register setting each, the extremes among them.
        // Time mostly moves forward in steps scaled to the settings, so that
        // holds arm, repeats fire and presses debounce; a few samples are noise.
        cur_code = GESTURE_NONE;
        btn_lvl = 1'b0;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: begin
                    v_gap = GAP_TIME_RST; v_arm = ARM_TIME_RST; v_rep = REPEAT_INTERVAL_RST;
                    v_lim = COUNT_LIMIT_RST; v_deb = DEBOUNCE_TIME_RST;
                end
                1: begin
                    v_gap = 16'd0; v_arm = 16'd0; v_rep = 16'd1; v_lim = 8'd1; v_deb = 16'd0;
                end
                2: begin
                    v_gap = 16'hFFFF; v_arm = 16'hFFFF; v_rep = 16'hFFFF;
                    v_lim = 8'hFF; v_deb = 16'hFFFF;
                end
                3: begin
                    v_gap = 16'd20; v_arm = 16'd5; v_rep = 16'd3; v_lim = 8'hFF; v_deb = 16'd2;
                end
                4: begin
                    v_gap = 16'd1000; v_arm = 16'd0; v_rep = 16'd0; v_lim = 8'd3; v_deb = 16'd10;
                end
                default: begin
                    v_gap = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 2000));
                    v_arm = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 2000));
                    v_rep = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                            : $urandom_range(1, 1500));
                    v_lim = 8'($urandom_range(1, 255));
                    v_deb = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                            : $urandom_range(0, 200));
                end
            endcase

            // Program only with the block idle
            wait_drained();
            write_reg(CFG_GAP_TIME, v_gap);
            write_reg(CFG_ARM_TIME, v_arm);
            write_reg(CFG_REPEAT_INTERVAL, v_rep);
            write_reg(CFG_COUNT_LIMIT, {8'd0, v_lim});
            write_reg(CFG_DEBOUNCE_TIME, v_deb);
            cfg_we <= 1'b0;

            scale = 32'(cfg_gap);
            if (cfg_arm > scale) scale = 32'(cfg_arm);
            if (cfg_repeat > scale) scale = 32'(cfg_repeat);
            if (cfg_debounce > scale) scale = 32'(cfg_debounce);
            if (scale < 4) scale = 4;
            ms_now = $urandom;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Hold off the receiver for a long stretch while samples keep coming
                if ((ph == 1 && n == 30) || (ph == 6 && n == 60))
                    hold_off_req = 1'b1;
                // Now and then pause until every result is back
                if ($urandom_range(0, 49) == 0)
                    wait_drained();

                if ($urandom_range(0, 99) < 5) begin
                    // Noise: any kind, any time, any fields
                    s.func = 1'($urandom_range(0, 1));
                    s.now_ms = $urandom;
                    s.gesture_code = 2'($urandom_range(0, 3));
                    s.button_level = 1'($urandom_range(0, 1));
                end
                else begin
                    case ($urandom_range(0, 9))
                        0, 1: step = 0;
                        2, 3, 4, 5: step = $urandom_range(0, scale / 8 + 1);
                        6, 7: begin
                            // Land near a programmed time to hit the boundaries
                            case ($urandom_range(0, 3))
                                0: step = 32'(cfg_gap);
                                1: step = 32'(cfg_arm);
                                2: step = 32'(cfg_repeat);
                                default: step = 32'(cfg_debounce);
                            endcase
                            if (step > 0 && $urandom_range(0, 1) == 1)
                                step--;
                        end
                        8: step = $urandom_range(0, scale * 2);
                        default: step = ($urandom_range(0, 9) == 0) ? $urandom
                                                                    : $urandom_range(0, scale);
                    endcase
                    ms_now = ms_now + step;
                    s.now_ms = ms_now;
                    if ($urandom_range(0, 3) == 0) begin
                        if ($urandom_range(0, 99) < 15)
                            btn_lvl = ~btn_lvl;
                        s.func = FUNC_BUTTON;
                        s.button_level = btn_lvl;
                        s.gesture_code = 2'($urandom_range(0, 3));
                    end
                    else begin
                        if ($urandom_range(0, 99) < 12)
                            cur_code = 2'($urandom_range(0, 3));
                        s.func = FUNC_GESTURE;
                        s.gesture_code = cur_code;
                        s.button_level = 1'($urandom_range(0, 1));
                    end
                end
                send_sample(s, 1'b0, '0);
            end
        end

        // Let the last results out, then keep the block quiet before the verdict
        wait_drained();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern that changes mode every so often, plus the
    // long hold-off that the stimulus asks for, counted here cycle by cycle.
    // ------------------------------------------------------------------
    initial begin : receiver
        rx_mode_t    mode;
        int          mode_left;
        int          hold_left;
        int unsigned rx_cycle;
        mode = RX_OPEN;
        mode_left = 0;
        hold_left = 0;
        rx_cycle = 0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            rx_cycle++;
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (mode_left == 0) begin
                case ($urandom_range(0, 2))
                    0: mode = RX_OPEN;
                    1: mode = RX_RANDOM;
                    default: mode = RX_PERIODIC;
                endcase
                mode_left = $urandom_range(32, 200);
            end
            else
                mode_left--;
            if (hold_left > 0) begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else begin
                case (mode)
                    RX_OPEN:     result_ch.ready <= 1'b1;
                    RX_RANDOM:   result_ch.ready <= ($urandom_range(0, 2) != 0);
                    RX_PERIODIC: result_ch.ready <= (rx_cycle % 3 != 0);
                    default:     result_ch.ready <= 1'b1;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: compare each result transfer, field by field, with the oldest
    // expectation. Report the first ten failures in full, count the rest.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : result_check
        result_t want;
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: add=%0d flush=%0d count=%0d flushed=%0d",
                             result_ch.data.add_event, result_ch.data.flush_event,
                             result_ch.data.count_now, result_ch.data.flushed_count);
                mismatches++;
            end
            else begin
                want = pending_results.pop_front();
                if (result_ch.data.add_event !== want.add_event ||
                    result_ch.data.flush_event !== want.flush_event ||
                    result_ch.data.count_now !== want.count_now ||
                    result_ch.data.flushed_count !== want.flushed_count) begin
                    if (mismatches < 10)
                        $display({"mismatch: expected add=%0d flush=%0d count=%0d flushed=%0d,",
                                  " got add=%0d flush=%0d count=%0d flushed=%0d"},
                                 want.add_event, want.flush_event,
                                 want.count_now, want.flushed_count,
                                 result_ch.data.add_event, result_ch.data.flush_event,
                                 result_ch.data.count_now, result_ch.data.flushed_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk) begin : watchdog
        int quiet;
        if (rst_n !== 1'b1)
            quiet = 0;
        else if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
                 (result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
            quiet = 0;
        else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

endmodule
